>>> rtl/assert_macros.svh
// Assertion macros used by the scheduler checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

>>> rtl/rts_pkg.sv
// Types and constants of the task scheduler.
package rts_pkg;

	typedef enum logic [2:0] {
		OP_CREATE = 3'd0,
		OP_DELAY  = 3'd1,
		OP_TICK   = 3'd2,
		OP_SWITCH = 3'd3,
		OP_WAIT   = 3'd4,
		OP_SIGNAL = 3'd5
	} op_e;

	localparam logic [1:0] PLACE_NONE   = 2'd0;
	localparam logic [1:0] PLACE_READY  = 2'd1;
	localparam logic [1:0] PLACE_WAKE_A = 2'd2;

	// widest level and stamp over the supported parameter range
	localparam int LEVEL_MAX_W = 5;
	localparam int STAMP_MAX_W = 7;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  task_id;
		logic [7:0]  priority_req;
		logic [31:0] ticks;
		logic [1:0]  event_id;
	} sched_in_t;

	typedef struct packed {
		logic       ok;
		logic       switch_needed;
		logic [3:0] current_task;
		logic       current_valid;
	} sched_out_t;

	// update of the entry at the table's read index
	typedef struct packed {
		logic                   apply;
		logic                   leave;
		logic                   set_task;
		logic [LEVEL_MAX_W-1:0] level;
		logic                   set_place;
		logic [1:0]             place;
		logic                   set_wait;
		logic [1:0]             event_id;
	} tbl_cmd_t;

	typedef struct packed {
		logic                   valid;
		logic [LEVEL_MAX_W-1:0] level;
		logic [1:0]             place;
		logic                   waiting;
		logic [1:0]             event_id;
		logic [STAMP_MAX_W-1:0] stamp;
	} tbl_entry_t;

endpackage

>>> rtl/rts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/rts_table.sv
// Task table: per-task state, queue stamps and waiter count.
module rts_table #(
	parameter int NUM_TASKS  = 16,
	parameter int NUM_LEVELS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(NUM_TASKS)-1:0] rd_idx,
	input  rts_pkg::tbl_cmd_t            cmd,
	output rts_pkg::tbl_entry_t          entry
);
	import rts_pkg::*;

	localparam int TW = $clog2(NUM_TASKS);
	localparam int LW = $clog2(NUM_LEVELS);
	localparam int SW = $clog2(NUM_TASKS + 1);

	logic          valid_q   [NUM_TASKS];
	logic [LW-1:0] level_q   [NUM_TASKS];
	logic [1:0]    place_q   [NUM_TASKS];
	logic          waiting_q [NUM_TASKS];
	logic [1:0]    event_q   [NUM_TASKS];
	logic [SW-1:0] stamp_q   [NUM_TASKS];
	logic [SW-1:0] wait_cnt_q;

	logic          leaving;
	logic [SW-1:0] stamp_sel;
	logic [SW-1:0] base_cnt;

	assign stamp_sel = stamp_q[rd_idx];
	assign leaving   = cmd.apply && cmd.leave && waiting_q[rd_idx];
	assign base_cnt  = wait_cnt_q - SW'(leaving);

	always_comb begin
		entry          = '0;
		entry.valid    = valid_q[rd_idx];
		entry.level    = LEVEL_MAX_W'(level_q[rd_idx]);
		entry.place    = place_q[rd_idx];
		entry.waiting  = waiting_q[rd_idx];
		entry.event_id = event_q[rd_idx];
		entry.stamp    = STAMP_MAX_W'(stamp_sel);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				valid_q[i]   <= 1'b0;
				level_q[i]   <= '0;
				place_q[i]   <= PLACE_NONE;
				waiting_q[i] <= 1'b0;
			end
			wait_cnt_q <= '0;
		end else if (cmd.apply) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				if (TW'(i) == rd_idx) begin
					if (cmd.set_wait) begin
						waiting_q[i] <= 1'b1;
					end else if (cmd.leave) begin
						waiting_q[i] <= 1'b0;
					end
					if (cmd.set_task) begin
						valid_q[i] <= 1'b1;
						level_q[i] <= LW'(cmd.level);
					end
					if (cmd.set_place) begin
						place_q[i] <= cmd.place;
					end
				end
			end
			wait_cnt_q <= base_cnt + SW'(cmd.set_wait);
		end
	end

	// stamps and event ids are only read once written
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				// close the gap left by the task that leaves
				if (leaving && waiting_q[i] && stamp_q[i] > stamp_sel) begin
					stamp_q[i] <= stamp_q[i] - SW'(1);
				end
				if (TW'(i) == rd_idx && cmd.set_wait) begin
					stamp_q[i] <= base_cnt;
					event_q[i] <= cmd.event_id;
				end
			end
		end
	end
endmodule

>>> rtl/rtos_task_scheduler.sv
// Priority round-robin task scheduler. One operation per transfer on the input
// channel, one result per operation. Tick, switch and signal with a valid event
// id walk the task table one entry per cycle, a pace set by that single table
// read port (tick also reads wake times from a RAM with registered read); all
// other operations go from idle straight to the result state. Input ready is
// high only between operations; a finished result sits in the output register.
module rtos_task_scheduler #(
	parameter int NUM_TASKS  = 16,
	parameter int NUM_LEVELS = 8,
	parameter int NUM_EVENTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rts_pkg::sched_in_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rts_pkg::sched_out_t out_data
);
	import rts_pkg::*;

	localparam int TW = $clog2(NUM_TASKS);
	localparam int LW = $clog2(NUM_LEVELS);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_TICK  = 7'b0000010,
		S_SIG   = 7'b0000100,
		S_SIGFN = 7'b0001000,
		S_SW    = 7'b0010000,
		S_SWFN  = 7'b0100000,
		S_RESP  = 7'b1000000
	} state_e;

	state_e        state_q;
	logic          ok_q, sw_q;
	logic [TW:0]   cnt_q;
	logic [TW-1:0] run_task_q;
	logic          run_valid_q;
	logic [LW-1:0] cur_lvl_q;
	logic [31:0]   tick_q;
	logic          swap_q;
	logic [TW-1:0] rr_q [NUM_LEVELS];
	logic [1:0]    ev_q;
	logic [TW-1:0] idx_s1;
	logic          v_s1;
	logic          best_v_q;
	logic [TW-1:0] best_idx_q;
	logic [LW-1:0] best_lvl_q;
	logic [STAMP_MAX_W-1:0] best_stamp_q;
	logic [TW-1:0] first_idx_q;
	logic          after_v_q;
	logic [TW-1:0] after_idx_q;
	sched_out_t    out_q;
	logic          out_valid_q;

	logic          accept;
	logic [TW-1:0] rd_idx;
	tbl_cmd_t      cmd;
	tbl_entry_t    e;
	logic [LW-1:0] e_lvl;
	logic [TW-1:0] scan_t;
	logic          id_ok, ev_ok;
	logic [LW-1:0] req_lvl;
	logic [TW-1:0] id_idx;
	logic [31:0]   wake;
	logic [1:0]    wake_place;
	logic          ram_we;
	logic [31:0]   ram_rdata;
	logic          tick_hit;
	logic          sig_better;
	logic          sw_ready;
	logic          after_hit;
	logic          last_scan;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign id_ok   = 32'(in_data.task_id) < NUM_TASKS;
	assign ev_ok   = 32'(in_data.event_id) < NUM_EVENTS;
	assign req_lvl = (32'(in_data.priority_req) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
		: LW'(in_data.priority_req);
	assign id_idx  = TW'(in_data.task_id);
	assign wake    = tick_q + in_data.ticks;
	assign wake_place = 2'(PLACE_WAKE_A + {1'b0, (wake < tick_q) ? ~swap_q : swap_q});

	assign scan_t    = cnt_q[TW-1:0];
	assign e_lvl     = LW'(e.level);
	assign last_scan = (cnt_q == (TW+1)'(NUM_TASKS - 1));

	always_comb begin
		priority case (1'b1)
			state_q[0]: rd_idx = (op_e'(in_data.op) == OP_CREATE) ? id_idx : run_task_q;
			state_q[1]: rd_idx = idx_s1;
			state_q[3]: rd_idx = best_idx_q;
			default:    rd_idx = scan_t;
		endcase
	end

	rts_table #(
		.NUM_TASKS (NUM_TASKS),
		.NUM_LEVELS(NUM_LEVELS)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_idx(rd_idx),
		.cmd   (cmd),
		.entry (e)
	);

	assign ram_we = accept && in_data.ticks != 32'd0 && run_valid_q &&
		(op_e'(in_data.op) == OP_DELAY || (op_e'(in_data.op) == OP_WAIT && ev_ok));

	rts_ram #(
		.WIDTH(32),
		.DEPTH(NUM_TASKS)
	) u_wake_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(run_task_q),
		.wdata(wake),
		.raddr(scan_t),
		.rdata(ram_rdata)
	);

	assign tick_hit   = v_s1 && e.place == 2'(PLACE_WAKE_A + {1'b0, swap_q}) &&
		tick_q >= ram_rdata;
	assign sig_better = e.waiting && e.event_id == ev_q && (!best_v_q ||
		e_lvl > best_lvl_q || (e_lvl == best_lvl_q && e.stamp < best_stamp_q));
	assign sw_ready   = e.valid && e.place == PLACE_READY;
	assign after_hit  = scan_t > rr_q[e_lvl];

	always_comb begin
		cmd = '0;
		priority case (1'b1)
			state_q[0]: begin
				if (accept) begin
					unique case (op_e'(in_data.op))
						OP_CREATE: begin
							cmd.apply     = id_ok;
							cmd.leave     = 1'b1;
							cmd.set_task  = 1'b1;
							cmd.level     = LEVEL_MAX_W'(req_lvl);
							cmd.set_place = 1'b1;
							cmd.place     = PLACE_READY;
						end
						OP_DELAY: begin
							cmd.apply     = run_valid_q && in_data.ticks != 32'd0;
							cmd.set_place = 1'b1;
							cmd.place     = wake_place;
						end
						OP_WAIT: begin
							cmd.apply     = run_valid_q && ev_ok;
							cmd.leave     = 1'b1;
							cmd.set_wait  = 1'b1;
							cmd.event_id  = in_data.event_id;
							cmd.set_place = 1'b1;
							cmd.place     = (in_data.ticks != 32'd0) ? wake_place : PLACE_NONE;
						end
						default: cmd = '0;
					endcase
				end
			end
			state_q[1]: begin
				cmd.apply     = tick_hit;
				cmd.leave     = 1'b1;
				cmd.set_place = 1'b1;
				cmd.place     = PLACE_READY;
			end
			state_q[3]: begin
				cmd.apply     = best_v_q;
				cmd.leave     = 1'b1;
				cmd.set_place = 1'b1;
				cmd.place     = PLACE_READY;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ok_q         <= 1'b0;
			sw_q         <= 1'b0;
			cnt_q        <= '0;
			run_task_q   <= '0;
			run_valid_q  <= 1'b0;
			cur_lvl_q    <= '0;
			tick_q       <= '0;
			swap_q       <= 1'b0;
			ev_q         <= '0;
			idx_s1       <= '0;
			v_s1         <= 1'b0;
			best_v_q     <= 1'b0;
			best_idx_q   <= '0;
			best_lvl_q   <= '0;
			best_stamp_q <= '0;
			first_idx_q  <= '0;
			after_v_q    <= 1'b0;
			after_idx_q  <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				rr_q[l] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ok_q     <= (op_e'(in_data.op) == OP_CREATE) && id_ok;
						sw_q     <= 1'b0;
						cnt_q    <= '0;
						v_s1     <= 1'b0;
						best_v_q <= 1'b0;
						after_v_q <= 1'b0;
						unique case (op_e'(in_data.op))
							OP_CREATE: begin
								state_q <= S_RESP;
								if (id_ok) begin
									if (!run_valid_q || cur_lvl_q < req_lvl) begin
										run_task_q  <= id_idx;
										run_valid_q <= 1'b1;
										cur_lvl_q   <= req_lvl;
									end else if (run_task_q == id_idx) begin
										cur_lvl_q <= req_lvl;
									end
								end
							end
							OP_TICK: begin
								tick_q <= tick_q + 32'd1;
								if (tick_q == '1) begin
									swap_q <= ~swap_q;
								end
								state_q <= S_TICK;
							end
							OP_SWITCH: state_q <= S_SW;
							OP_SIGNAL: begin
								ev_q    <= in_data.event_id;
								state_q <= ev_ok ? S_SIG : S_RESP;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_TICK: begin
					// read wake time of one slot, check it in the following cycle
					idx_s1 <= scan_t;
					v_s1   <= (cnt_q != (TW+1)'(NUM_TASKS));
					if (tick_hit && (!run_valid_q || e_lvl >= cur_lvl_q)) begin
						sw_q <= 1'b1;
					end
					if (cnt_q == (TW+1)'(NUM_TASKS)) begin
						state_q <= S_RESP;
					end else begin
						cnt_q <= cnt_q + (TW+1)'(1);
					end
				end
				S_SIG: begin
					if (sig_better) begin
						best_v_q     <= 1'b1;
						best_idx_q   <= scan_t;
						best_lvl_q   <= e_lvl;
						best_stamp_q <= e.stamp;
					end
					if (last_scan) begin
						state_q <= S_SIGFN;
					end else begin
						cnt_q <= cnt_q + (TW+1)'(1);
					end
				end
				S_SIGFN: begin
					if (best_v_q) begin
						ok_q <= !run_valid_q || best_lvl_q >= cur_lvl_q;
					end
					state_q <= S_RESP;
				end
				S_SW: begin
					if (sw_ready) begin
						if (!best_v_q || e_lvl > best_lvl_q) begin
							best_v_q    <= 1'b1;
							best_lvl_q  <= e_lvl;
							first_idx_q <= scan_t;
							after_v_q   <= after_hit;
							after_idx_q <= scan_t;
						end else if (e_lvl == best_lvl_q && !after_v_q && after_hit) begin
							after_v_q   <= 1'b1;
							after_idx_q <= scan_t;
						end
					end
					if (last_scan) begin
						state_q <= S_SWFN;
					end else begin
						cnt_q <= cnt_q + (TW+1)'(1);
					end
				end
				S_SWFN: begin
					if (!best_v_q) begin
						run_valid_q <= 1'b0;
						run_task_q  <= '0;
					end else begin
						rr_q[best_lvl_q] <= after_v_q ? after_idx_q : first_idx_q;
						run_task_q       <= after_v_q ? after_idx_q : first_idx_q;
						run_valid_q      <= 1'b1;
						cur_lvl_q        <= best_lvl_q;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_q.ok            <= ok_q;
						out_q.switch_needed <= sw_q;
						out_q.current_task  <= 4'(run_task_q);
						out_q.current_valid <= run_valid_q;
						out_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/rts_checker.sv
// Port-level checks of the task scheduler, bound to the top level.
`include "assert_macros.svh"

module rts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input rts_pkg::sched_in_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input rts_pkg::sched_out_t out_data
);
	import rts_pkg::*;

	`RTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	`RTS_ASSERT_NOW(a_idle_task_zero, out_valid && !out_data.current_valid, out_data.current_task == 4'd0)
	`RTS_ASSERT_NOW(a_flags_exclusive, out_valid, !(out_data.ok && out_data.switch_needed))
	`RTS_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
endmodule

bind rtos_task_scheduler rts_checker u_rts_checker (.*);

>>> test/testbench.sv
// Self-checking testbench of the priority round-robin task scheduler.
`timescale 1ns / 1ps

module testbench;
	import rts_pkg::*;

	localparam int NTASK = 16;
	localparam int NLVL  = 8;
	localparam int NEV   = 4;
	localparam logic [1:0] PLACE_WAKE_B = 2'd3;

	class sched_scoreboard;
		bit          valid [NTASK];
		logic [2:0]  level [NTASK];
		logic [1:0]  place [NTASK];
		logic [31:0] wake [NTASK];
		bit          waiting [NTASK];
		logic [1:0]  evq [NTASK];
		int          stamp [NTASK];
		logic [3:0]  cursor [NLVL];
		logic [3:0]  run_task;
		bit          run_valid;
		logic [31:0] count;
		bit          swap;
		sched_out_t  pending [$];
		int          errors;
		int          checked;

		function new();
			for (int i = 0; i < NTASK; i++) begin
				valid[i] = 0; level[i] = 0; place[i] = PLACE_NONE; wake[i] = 0;
				waiting[i] = 0; evq[i] = 0; stamp[i] = 0;
			end
			for (int l = 0; l < NLVL; l++)
				cursor[l] = 0;
			run_task = 0; run_valid = 0; count = 0; swap = 0; errors = 0; checked = 0;
		endfunction

		function void drop_from_queue(int t);
			if (!waiting[t])
				return;
			for (int u = 0; u < NTASK; u++)
				if (waiting[u] && stamp[u] > stamp[t])
					stamp[u]--;
			waiting[t] = 0;
		endfunction

		function void park(int t, logic [31:0] n);
			logic [31:0] w;
			w = count + n;
			wake[t] = w;
			place[t] = PLACE_WAKE_A + ((w < count) ? (swap ^ 1'b1) : swap);
		endfunction

		function bit beats_current(int t);
			return !run_valid || level[t] >= level[run_task];
		endfunction

		function void note_input(sched_in_t d);
			sched_out_t r;
			int cur, top, best, n;
			logic [2:0] lvl;
			r = '0;
			cur = run_task;
			case (d.op)
				OP_CREATE: begin
					lvl = (d.priority_req >= NLVL) ? 3'(NLVL - 1) : d.priority_req[2:0];
					drop_from_queue(d.task_id);
					valid[d.task_id] = 1; level[d.task_id] = lvl;
					place[d.task_id] = PLACE_READY;
					if (!run_valid || level[cur] < lvl) begin
						run_task = d.task_id; run_valid = 1;
					end
					r.ok = 1;
				end
				OP_DELAY:
					if (d.ticks != 0 && run_valid)
						park(cur, d.ticks);
				OP_TICK: begin
					count = count + 32'd1;
					if (count == 0)
						swap ^= 1'b1;
					for (int t = 0; t < NTASK; t++)
						if (place[t] == PLACE_WAKE_A + swap && count >= wake[t]) begin
							drop_from_queue(t);
							place[t] = PLACE_READY;
							if (beats_current(t))
								r.switch_needed = 1;
						end
				end
				OP_SWITCH: begin
					top = -1;
					for (int l = NLVL - 1; l >= 0 && top < 0; l--)
						for (int t = 0; t < NTASK; t++)
							if (valid[t] && place[t] == PLACE_READY && level[t] == l)
								top = l;
					if (top < 0) begin
						run_valid = 0; run_task = 0;
					end else begin
						for (int k = 1; k <= NTASK; k++) begin
							n = (cursor[top] + k) % NTASK;
							if (valid[n] && place[n] == PLACE_READY && level[n] == top) begin
								cursor[top] = 4'(n); run_task = 4'(n); run_valid = 1;
								break;
							end
						end
					end
				end
				OP_WAIT:
					if (run_valid) begin
						drop_from_queue(cur);
						n = 0;
						for (int u = 0; u < NTASK; u++)
							n += waiting[u];
						stamp[cur] = n; waiting[cur] = 1; evq[cur] = d.event_id;
						if (d.ticks != 0)
							park(cur, d.ticks);
						else
							place[cur] = PLACE_NONE;
					end
				OP_SIGNAL: begin
					best = -1;
					for (int t = 0; t < NTASK; t++)
						if (waiting[t] && evq[t] == d.event_id)
							if (best < 0 || level[t] > level[best] ||
									(level[t] == level[best] && stamp[t] < stamp[best]))
								best = t;
					if (best >= 0) begin
						drop_from_queue(best);
						place[best] = PLACE_READY;
						r.ok = beats_current(best);
					end
				end
				default: ;
			endcase
			r.current_task = run_valid ? run_task : 4'd0;
			r.current_valid = run_valid;
			pending.push_back(r);
		endfunction

		function void check_result(sched_out_t got);
			sched_out_t want;
			checked++;
			if (pending.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			want = pending.pop_front();
			if (got.ok !== want.ok) report("ok differs");
			if (got.switch_needed !== want.switch_needed) report("switch_needed differs");
			if (got.current_task !== want.current_task) report("current_task differs");
			if (got.current_valid !== want.current_valid) report("current_valid differs");
		endfunction

		function void report(string what);
			errors++;
			if (errors <= 30)
				$display("MISMATCH %0t: %s", $time, what);
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_ready;
	sched_in_t  in_data = '0;
	logic       out_valid;
	logic       out_ready = 0;
	sched_out_t out_data;

	sched_scoreboard sb;
	bit calm = 0;
	int sent = 0;

	rtos_task_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// sample the result side at the edge, before drivers update
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);

	// consumer stalls in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 13);
				repeat (n) @(posedge clk);
			end
			out_ready <= 1;
			n = $urandom_range(1, 20);
			repeat (n) @(posedge clk);
		end
	end

	// valid stays up between transfers unless an idle burst drops it
	task automatic send_op(input sched_in_t d);
		int n;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 13);
			repeat (n) @(posedge clk);
		end
		in_data <= d;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_input(d);
		sent++;
	endtask

	task automatic send_fields(input op_e op, input int id, input int pr,
			input logic [31:0] tk, input int ev);
		sched_in_t d;
		d.op = op; d.task_id = 4'(id); d.priority_req = 8'(pr); d.ticks = tk;
		d.event_id = 2'(ev);
		send_op(d);
	endtask

	function automatic logic [31:0] pick_ticks();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return $urandom;
			2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic send_random();
		sched_in_t d;
		int r;
		d = $bits(sched_in_t)'({$urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 12) d.op = OP_CREATE;
		else if (r < 24) d.op = OP_DELAY;
		else if (r < 52) d.op = OP_TICK;
		else if (r < 70) d.op = OP_SWITCH;
		else if (r < 84) d.op = OP_WAIT;
		else if (r < 98) d.op = OP_SIGNAL;
		else d.op = 3'($urandom_range(6, 7));
		if (d.op != OP_CREATE || $urandom_range(0, 3) != 0)
			d.priority_req = 8'($urandom_range(0, 9));
		d.ticks = pick_ticks();
		send_op(d);
	endtask

	initial begin
		int waited;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty cases, extremes, every op
		send_fields(OP_SWITCH, 0, 0, 0, 0);
		send_fields(OP_DELAY, 0, 0, 5, 0);
		send_fields(OP_WAIT, 0, 0, 0, 3);
		send_fields(OP_SIGNAL, 0, 0, 0, 2);
		send_fields(OP_TICK, 0, 0, 0, 0);
		send_fields(OP_CREATE, 0, 0, 0, 0);
		send_fields(OP_CREATE, 15, 255, 32'hFFFF_FFFF, 3);
		send_fields(OP_CREATE, 7, 7, 0, 0);
		send_fields(OP_CREATE, 3, 128, 0, 0);
		send_fields(OP_WAIT, 0, 0, 0, 1);
		send_fields(OP_SWITCH, 0, 0, 0, 0);
		send_fields(OP_WAIT, 0, 0, 3, 1);
		send_fields(OP_SWITCH, 0, 0, 0, 0);
		send_fields(OP_WAIT, 0, 0, 0, 2);
		send_fields(OP_SIGNAL, 0, 0, 0, 1);
		send_fields(OP_CREATE, 15, 2, 0, 0);
		send_fields(OP_SWITCH, 0, 0, 0, 0);
		send_fields(OP_DELAY, 0, 0, 32'hFFFF_FFFF, 0);
		send_fields(OP_DELAY, 0, 0, 0, 0);
		send_fields(OP_TICK, 0, 0, 0, 0);
		send_fields(OP_TICK, 0, 0, 0, 0);
		send_fields(OP_SIGNAL, 0, 0, 0, 2);
		begin
			sched_in_t d;
			d = '1;
			send_op(d);
		end
		for (int i = 0; i < 1850; i++) begin
			if (i == 1650)
				calm = 1;
			send_random();
		end
		in_valid <= 0;
		waited = 0;
		while (sb.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		$display("Ran %0d operations, %0d results checked; all six ops plus illegal codes,",
			sent, sb.checked);
		$display("wake-list wrap, event queues with timeouts and round-robin switching.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("testbench failed");
		$finish;
	end
endmodule
